// File: sv/mof_pkg.sv
`default_nettype none
package mof_pkg;

  typedef struct packed {
    logic [11:0]        cell_index;
    logic [11:0]        neighbor_index;
    logic [11:0]        edge_cell;
    logic signed [31:0] elev_here;
    logic signed [31:0] elev_next;
    logic [30:0]        depth_here;
    logic [30:0]        depth_next;
    logic [30:0]        depth_edge;
    logic [30:0]        rough_here;
    logic [30:0]        rough_next;
    logic [30:0]        rough_edge;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] flow_amount;
    logic [30:0]        edge_outflow;
    logic [1:0]         step_status;
  } out_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] q;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic        mode;
    logic [63:0] x;
  } root_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] y;
  } root_rsp_t;

  localparam logic ROOT_SQRT = 1'b0;
  localparam logic ROOT_CBRT = 1'b1;

  localparam logic [2:0] REG_CELL_WIDTH   = 3'd0;
  localparam logic [2:0] REG_TIME_STEP    = 3'd1;
  localparam logic [2:0] REG_DEF_ROUGH    = 3'd2;
  localparam logic [2:0] REG_MIN_DEPTH    = 3'd3;
  localparam logic [2:0] REG_USE_CELL_RGH = 3'd4;
  localparam logic [2:0] REG_OUTFLOW_EN   = 3'd5;
  localparam logic [2:0] REG_OUTLET_SIDE  = 3'd6;
  localparam logic [2:0] REG_OUTLET_CELL  = 3'd7;

  localparam logic [1:0] ST_FLAT    = 2'd0;
  localparam logic [1:0] ST_SHALLOW = 2'd1;
  localparam logic [1:0] ST_ROUTED  = 2'd2;

  localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

  localparam logic [30:0] RST_CELL_WIDTH = 31'd1966080;
  localparam logic [30:0] RST_TIME_STEP  = 31'd65536;
  localparam logic [30:0] RST_DEF_ROUGH  = 31'd2294;
  localparam logic [30:0] RST_MIN_DEPTH  = 31'd66;

  function automatic logic [30:0] nz31(input logic [30:0] v);
    return (v == 31'd0) ? 31'd1 : v;
  endfunction

endpackage
`default_nettype wire

// File: sv/mof_div.sv
`default_nettype none
// restoring divider, one quotient bit per cycle, saturates at 2^31-1
module mof_div (
  input  wire                clk,
  input  wire                rst_n,
  input  mof_pkg::div_req_t  req,
  output mof_pkg::div_rsp_t  rsp
);

  logic        busy_r;
  logic        done_r;
  logic        sat_r;
  logic [4:0]  cnt_r;
  logic [30:0] rem_r;
  logic [30:0] low_r;
  logic [30:0] q_r;
  logic [30:0] d_r;
  logic [31:0] trial;
  logic        fits;

  assign trial = {rem_r, low_r[30]};
  assign fits  = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd30;
        d_r    <= req.divisor;
        sat_r  <= req.dividend >= {2'b00, req.divisor, 31'd0};
        rem_r  <= req.dividend[61:31];
        low_r  <= req.dividend[30:0];
      end else if (busy_r) begin
        rem_r <= fits ? 31'(trial - {1'b0, d_r}) : trial[30:0];
        low_r <= {low_r[29:0], 1'b0};
        q_r   <= {q_r[29:0], fits};
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 5'd1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = sat_r ? mof_pkg::MAG_MAX : q_r;

endmodule
`default_nettype wire

// File: sv/mof_root.sv
`default_nettype none
// bit-serial integer square root (32 steps) and cube root (22 steps)
module mof_root (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mof_pkg::root_req_t  req,
  output mof_pkg::root_rsp_t  rsp
);

  logic        busy_r;
  logic        done_r;
  logic        mode_r;
  logic [4:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [21:0] y_r;
  logic [43:0] y2_r;

  logic [63:0] sq_bit;
  logic [63:0] sq_sum;
  logic [5:0]  cb_sh;
  logic [21:0] yy;
  logic [43:0] yy2;
  logic [43:0] b0;
  logic [45:0] b;
  logic [63:0] b_wide;
  logic        cb_fit;
  logic        last;

  always_comb begin
    sq_bit = 64'h4000_0000_0000_0000 >> {cnt_r, 1'b0};
    sq_sum = r_r + sq_bit;
    cb_sh  = 6'd63 - ({1'b0, cnt_r} + {cnt_r, 1'b0});
    yy     = {y_r[20:0], 1'b0};
    yy2    = {y2_r[41:0], 2'b00};
    b0     = yy2 + {22'd0, yy};
    b      = {1'b0, b0, 1'b0} + {2'b00, b0} + 46'd1;
    b_wide = {18'd0, b};
    cb_fit = (x_r >> cb_sh) >= b_wide;
    last   = (mode_r == mof_pkg::ROOT_CBRT) ? (cnt_r == 5'd21) : (cnt_r == 5'd31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        mode_r <= req.mode;
        cnt_r  <= 5'd0;
        x_r    <= req.x;
        r_r    <= 64'd0;
        y_r    <= 22'd0;
        y2_r   <= 44'd0;
      end else if (busy_r) begin
        if (mode_r == mof_pkg::ROOT_SQRT) begin
          if (x_r >= sq_sum) begin
            x_r <= x_r - sq_sum;
            r_r <= (r_r >> 1) + sq_bit;
          end else begin
            r_r <= r_r >> 1;
          end
        end else begin
          if (cb_fit) begin
            x_r  <= x_r - (b_wide << cb_sh);
            y_r  <= yy + 22'd1;
            y2_r <= yy2 + {21'd0, yy, 1'b0} + 44'd1;
          end else begin
            y_r  <= yy;
            y2_r <= yy2;
          end
        end
        cnt_r <= cnt_r + 5'd1;
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.y    = (mode_r == mof_pkg::ROOT_CBRT) ? {10'd0, y_r} : r_r[31:0];

endmodule
`default_nettype wire

// File: sv/mof_mul.sv
`default_nettype none
// shared 32x32 multiplier, product registered and held until next load
module mof_mul (
  input  wire         clk,
  input  wire         en,
  input  wire  [31:0] a,
  input  wire  [31:0] b,
  output logic [63:0] p_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= a * b;
    end
  end

endmodule
`default_nettype wire

// File: sv/mof_flux_mem.sv
`default_nettype none
module mof_flux_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [31:0]   wdata,
  input  wire  [AW-1:0] raddr,
  output logic [31:0]   rdata_r
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/manning_overland_flow_step.sv
`default_nettype none
// one request in flight; the bit-serial root unit (32 or 22 steps) and the 31-step divider
// serve the routed path; each flux memory read-modify-write passes through S_RD, then S_WR
// a new request is accepted only in S_IDLE; a finished result waits in the output register
// reset: synchronous; a clearing pass writes zero to every flux memory address,
// requests are held off until it ends
module manning_overland_flow_step #(
  parameter int CELL_COUNT = 4096
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  mof_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output mof_pkg::out_req_t  out_data,
  input  wire                cfg_we,
  input  wire  [2:0]         cfg_index,
  input  wire  [30:0]        cfg_wdata
);

  localparam int AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int IW = 12;
  localparam int RW = IW + AW + 1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SLOPE_GO, S_SLOPE_WAIT, S_CHECK,
    S_M_SQRT, S_M_SQRTW, S_M_CBRT, S_M_CBRTW, S_M_P, S_M_P2,
    S_PP_ISSUE, S_PP_ACC, S_M_DIV, S_M_DIVW,
    S_RD, S_WR, S_DCHK, S_VOL, S_VOL2, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [30:0] cell_width_r, time_step_r, def_rough_r, min_depth_r;
  logic        use_cell_r, outflow_en_r;
  logic [2:0]  outlet_side_r;
  logic [11:0] outlet_cell_r;

  // item
  mof_pkg::in_req_t req_r;
  logic [RW-1:0] red_v_r [4];
  logic [3:0]    red_k_r;
  logic          red_on_r;
  logic          pos_r;
  logic [30:0]   s_r, h_r, n_r;
  logic [23:0]   a_r;
  logic          big_r;
  logic [25:0]   b_r;
  logic [38:0]   t_r;
  logic [40:0]   p_r;
  logic [79:0]   prod_r;
  logic [1:0]    pp_k_r;
  logic          pass_r;
  logic [30:0]   main_q_r, drain_r;
  logic [1:0]    status_r;
  logic [1:0]    op_r;
  logic [AW-1:0] acc_addr_r;
  logic signed [32:0] delta_r;
  logic [63:0]   vol_r;
  logic [AW-1:0] clr_addr_r;
  logic          out_valid_r;
  mof_pkg::out_req_t out_r;

  // datapath
  logic [30:0] w, nd;
  logic signed [33:0] num;
  logic [33:0] mag;
  logic [RW-1:0] red_lim;
  logic [AW-1:0] src_i, nb_i, edge_i, oc_i;
  mof_pkg::div_req_t  div_req;
  mof_pkg::div_rsp_t  div_rsp;
  mof_pkg::root_req_t root_req;
  mof_pkg::root_rsp_t root_rsp;
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] pp_a, pp_b;
  logic [79:0] pp_add;
  logic [61:0] h2;
  logic        h2_big;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0] mem_wdata, rdata;
  logic signed [33:0] fsum;
  logic [31:0] fsat;
  logic [64:0] vol_sum;
  logic        out_free;
  logic        prod_sat;

  assign w  = mof_pkg::nz31(cell_width_r);
  assign nd = mof_pkg::nz31(def_rough_r);

  assign src_i  = red_v_r[0][AW-1:0];
  assign nb_i   = red_v_r[1][AW-1:0];
  assign edge_i = red_v_r[2][AW-1:0];
  assign oc_i   = red_v_r[3][AW-1:0];
  assign red_lim = RW'(CELL_COUNT) << red_k_r;

  always_comb begin
    num = {{2{req_r.elev_here[31]}}, req_r.elev_here}
        - {{2{req_r.elev_next[31]}}, req_r.elev_next}
        + {3'd0, req_r.depth_here} - {3'd0, req_r.depth_next};
    mag = num[33] ? 34'(-num) : 34'(num);
  end

  always_comb begin
    case (pp_k_r)
      2'd0:    begin pp_a = t_r[31:0];          pp_b = p_r[31:0];          end
      2'd1:    begin pp_a = t_r[31:0];          pp_b = {23'd0, p_r[40:32]}; end
      2'd2:    begin pp_a = {25'd0, t_r[38:32]}; pp_b = p_r[31:0];          end
      default: begin pp_a = {25'd0, t_r[38:32]}; pp_b = {23'd0, p_r[40:32]}; end
    endcase
    case (pp_k_r)
      2'd0:    pp_add = {16'd0, mul_p};
      2'd3:    pp_add = {mul_p[15:0], 64'd0};
      default: pp_add = {mul_p[47:0], 32'd0};
    endcase
  end

  assign h2       = mul_p[61:0];
  assign h2_big   = h2 >= 62'h0000_8000_0000_0000;
  assign prod_sat = prod_r >= 80'h7FFF_FFFF_FFFF_FFFF;

  always_comb begin
    mul_en = 1'b0;
    mul_a  = 32'd0;
    mul_b  = 32'd0;
    div_req  = '0;
    root_req = '0;
    case (state_r)
      S_SLOPE_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {14'd0, mag, 16'd0};
        div_req.divisor  = w;
      end
      S_M_SQRT: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, h_r};
        mul_b  = {1'b0, h_r};
        root_req.start = 1'b1;
        root_req.mode  = mof_pkg::ROOT_SQRT;
        root_req.x     = {17'd0, s_r, 16'd0};
      end
      S_M_CBRT: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, w};
        mul_b  = {8'd0, a_r};
        root_req.start = 1'b1;
        root_req.mode  = mof_pkg::ROOT_CBRT;
        root_req.x     = h2_big ? {16'd0, h2[61:14]} : {1'b0, h2[46:0], 16'd0};
      end
      S_M_P: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, h_r};
        mul_b  = {6'd0, b_r};
      end
      S_PP_ISSUE: begin
        mul_en = 1'b1;
        mul_a  = pp_a;
        mul_b  = pp_b;
      end
      S_M_DIV: begin
        div_req.start    = !prod_sat;
        div_req.dividend = {prod_r[63:16], 16'd0};
        div_req.divisor  = n_r;
      end
      S_VOL: begin
        mul_en = 1'b1;
        mul_a  = {1'b0, drain_r};
        mul_b  = {1'b0, time_step_r};
      end
      default: ;
    endcase
  end

  // flux update with signed saturation
  always_comb begin
    fsum = {{2{rdata[31]}}, rdata} + {delta_r[32], delta_r};
    if (fsum > 34'sd2147483647) begin
      fsat = 32'h7FFF_FFFF;
    end else if (fsum < -34'sd2147483648) begin
      fsat = 32'h8000_0000;
    end else begin
      fsat = fsum[31:0];
    end
  end

  assign mem_we    = (state_r == S_CLEAR) || (state_r == S_WR);
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : acc_addr_r;
  assign mem_wdata = (state_r == S_CLEAR) ? 32'd0 : fsat;
  assign vol_sum   = {1'b0, vol_r} + {19'd0, mul_p[61:16]};
  assign out_free  = !out_valid_r || out_ready;

  mof_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mof_root u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (root_req),
    .rsp   (root_rsp)
  );

  mof_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  mof_flux_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (acc_addr_r),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= mof_pkg::RST_CELL_WIDTH;
      time_step_r   <= mof_pkg::RST_TIME_STEP;
      def_rough_r   <= mof_pkg::RST_DEF_ROUGH;
      min_depth_r   <= mof_pkg::RST_MIN_DEPTH;
      use_cell_r    <= 1'b0;
      outflow_en_r  <= 1'b0;
      outlet_side_r <= 3'd0;
      outlet_cell_r <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mof_pkg::REG_CELL_WIDTH:   cell_width_r  <= cfg_wdata;
        mof_pkg::REG_TIME_STEP:    time_step_r   <= cfg_wdata;
        mof_pkg::REG_DEF_ROUGH:    def_rough_r   <= cfg_wdata;
        mof_pkg::REG_MIN_DEPTH:    min_depth_r   <= cfg_wdata;
        mof_pkg::REG_USE_CELL_RGH: use_cell_r    <= cfg_wdata[0];
        mof_pkg::REG_OUTFLOW_EN:   outflow_en_r  <= cfg_wdata[0];
        mof_pkg::REG_OUTLET_SIDE:  outlet_side_r <= cfg_wdata[2:0];
        mof_pkg::REG_OUTLET_CELL:  outlet_cell_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      red_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
      vol_r       <= 64'd0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      // cell indices reduced modulo CELL_COUNT, one binary step a cycle
      if (red_on_r) begin
        for (int i = 0; i < 4; i++) begin
          if (red_v_r[i] >= red_lim) begin
            red_v_r[i] <= red_v_r[i] - red_lim;
          end
        end
        if (red_k_r == 4'd0) begin
          red_on_r <= 1'b0;
        end else begin
          red_k_r <= red_k_r - 4'd1;
        end
      end

      case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(CELL_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_r      <= in_data;
            red_v_r[0] <= RW'(in_data.cell_index);
            red_v_r[1] <= RW'(in_data.neighbor_index);
            red_v_r[2] <= RW'(in_data.edge_cell);
            red_v_r[3] <= RW'(outlet_cell_r);
            red_k_r    <= 4'(IW - 1);
            red_on_r   <= 1'b1;
            state_r    <= S_SLOPE_GO;
          end
        end
        S_SLOPE_GO: begin
          pos_r   <= !num[33] && (num != 34'sd0);
          state_r <= S_SLOPE_WAIT;
        end
        S_SLOPE_WAIT: begin
          if (div_rsp.done) begin
            s_r     <= div_rsp.q;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          main_q_r <= 31'd0;
          drain_r  <= 31'd0;
          h_r      <= pos_r ? req_r.depth_here : req_r.depth_next;
          n_r      <= use_cell_r ? mof_pkg::nz31(pos_r ? req_r.rough_here : req_r.rough_next)
                                 : nd;
          pass_r   <= 1'b0;
          if (s_r == 31'd0) begin
            status_r <= mof_pkg::ST_FLAT;
            state_r  <= S_DONE;
          end else if ((pos_r ? req_r.depth_here : req_r.depth_next) < min_depth_r) begin
            status_r <= mof_pkg::ST_SHALLOW;
            state_r  <= S_DONE;
          end else begin
            status_r <= mof_pkg::ST_ROUTED;
            state_r  <= S_M_SQRT;
          end
        end
        S_M_SQRT: state_r <= S_M_SQRTW;
        S_M_SQRTW: begin
          if (root_rsp.done) begin
            a_r     <= root_rsp.y[23:0];
            state_r <= S_M_CBRT;
          end
        end
        S_M_CBRT: begin
          big_r   <= h2_big;
          state_r <= S_M_CBRTW;
        end
        S_M_CBRTW: begin
          if (root_rsp.done) begin
            b_r     <= big_r ? {root_rsp.y[15:0], 10'd0} : root_rsp.y[25:0];
            t_r     <= mul_p[54:16];
            state_r <= S_M_P;
          end
        end
        S_M_P: state_r <= S_M_P2;
        S_M_P2: begin
          p_r     <= mul_p[56:16];
          prod_r  <= 80'd0;
          pp_k_r  <= 2'd0;
          state_r <= S_PP_ISSUE;
        end
        S_PP_ISSUE: state_r <= S_PP_ACC;
        S_PP_ACC: begin
          prod_r <= prod_r + pp_add;
          if (pp_k_r == 2'd3) begin
            state_r <= S_M_DIV;
          end else begin
            pp_k_r  <= pp_k_r + 2'd1;
            state_r <= S_PP_ISSUE;
          end
        end
        S_M_DIV: begin
          if (prod_sat) begin
            if (pass_r) begin
              drain_r <= mof_pkg::MAG_MAX;
              delta_r <= -33'sd2147483647;
              op_r    <= 2'd2;
            end else begin
              main_q_r   <= mof_pkg::MAG_MAX;
              delta_r    <= pos_r ? -33'sd2147483647 : 33'sd2147483647;
              acc_addr_r <= src_i;
              op_r       <= 2'd0;
            end
            state_r <= S_RD;
          end else begin
            state_r <= S_M_DIVW;
          end
        end
        S_M_DIVW: begin
          if (div_rsp.done) begin
            if (pass_r) begin
              drain_r <= div_rsp.q;
              delta_r <= -$signed({2'b00, div_rsp.q});
              op_r    <= 2'd2;
            end else begin
              main_q_r   <= div_rsp.q;
              delta_r    <= pos_r ? -$signed({2'b00, div_rsp.q}) : $signed({2'b00, div_rsp.q});
              acc_addr_r <= src_i;
              op_r       <= 2'd0;
            end
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_WR;
        S_WR: begin
          case (op_r)
            2'd0: begin
              // source first, then the neighbor, even when both are one cell
              acc_addr_r <= nb_i;
              delta_r    <= -delta_r;
              op_r       <= 2'd1;
              state_r    <= S_RD;
            end
            2'd1:    state_r <= S_DCHK;
            default: state_r <= S_VOL;
          endcase
        end
        S_DCHK: begin
          if (outflow_en_r && (outlet_side_r != 3'd0) && (nb_i != oc_i)) begin
            if ((outlet_side_r == 3'd1 || outlet_side_r == 3'd3) && !pos_r) begin
              h_r        <= req_r.depth_here;
              n_r        <= use_cell_r ? mof_pkg::nz31(req_r.rough_here) : nd;
              acc_addr_r <= src_i;
              pass_r     <= 1'b1;
              state_r    <= S_M_SQRT;
            end else if ((outlet_side_r == 3'd2 || outlet_side_r == 3'd4) && pos_r) begin
              h_r        <= req_r.depth_edge;
              n_r        <= use_cell_r ? mof_pkg::nz31(req_r.rough_edge) : nd;
              acc_addr_r <= edge_i;
              pass_r     <= 1'b1;
              state_r    <= S_M_SQRT;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            state_r <= S_DONE;
          end
        end
        S_VOL: state_r <= S_VOL2;
        S_VOL2: begin
          vol_r   <= vol_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : vol_sum[63:0];
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_r.flow_amount  <= pos_r ? $signed({1'b0, main_q_r})
                                        : -$signed({1'b0, main_q_r});
            out_r.edge_outflow <= drain_r;
            out_r.step_status  <= status_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
